@@ hw/rtl/tcw_pkg.sv @@
// tcw_pkg: geometry, field widths, codes and shared types of the text console writer.
// Standalone; imported by tcw_char_mem and text_console_writer.
package tcw_pkg;

	localparam int COLS   = 80;
	localparam int ROWS   = 25;
	localparam int CELLS  = COLS * ROWS;
	localparam int COL_W  = $clog2(COLS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int ADDR_W = $clog2(CELLS);

	// fixed field widths
	localparam int CHAR_W = 8;
	localparam int IDX_W  = 11;
	localparam int CLR_W  = 4;
	localparam int ATTR_W = 2 * CLR_W;
	localparam int WORD_W = ATTR_W + CHAR_W;
	localparam int SUM_W  = ((IDX_W > ADDR_W) ? IDX_W : ADDR_W) + 1;

	// stream packing
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 40;
	localparam int OUT_USER_W = 2;
	localparam int OUT_PAD_W  = OUT_DATA_W - WORD_W - 2 * IDX_W;

	// config port
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'b1;
	localparam logic [CLR_W-1:0] FG_RESET = 4'd7;
	localparam logic [CLR_W-1:0] BG_RESET = 4'd0;

	localparam logic FUNC_PUT  = 1'b0;
	localparam logic FUNC_READ = 1'b1;
	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

	typedef enum logic [1:0] {
		S_INIT,
		S_IDLE,
		S_CLEAR,
		S_RESP
	} state_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [CHAR_W-1:0] data;
	} mem_wr_t;

endpackage

@@ hw/rtl/tcw_char_mem.sv @@
// tcw_char_mem: character store, one write port and one registered read port.
// Depends on tcw_pkg for depth, widths and the write request struct.
module tcw_char_mem (
	input  logic                           clk,
	input  tcw_pkg::mem_wr_t               wr,
	input  logic                           rd_en,
	input  logic [tcw_pkg::ADDR_W-1:0]     rd_addr,
	output logic [tcw_pkg::CHAR_W-1:0]     rd_data
);
	import tcw_pkg::*;

	logic [CHAR_W-1:0] mem_q [CELLS];
	logic [CHAR_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hw/rtl/text_console_writer.sv @@
// text_console_writer: 80x25 text console with cursor, wrap, scroll and cell read-back.
// Depends on tcw_pkg and tcw_char_mem.
//
//   channel   dir  handshake          payload
//   s_*       in   s_tvalid/s_tready  tuser: func; tdata: char_code, cell_index
//   m_*       out  m_tvalid/m_tready  tuser: wrote, scrolled; tdata: cell_word,
//                                     write_index, cursor_pos
//   cfg_*     in   cfg_we             cfg_index, cfg_data (fg_colour, bg_colour)
//
// A put or read is accepted (store access), then loads the output register.
// A put that scrolls also clears a row: rows live in a ring, so a scroll only moves the
// ring base and clears the old top row, one cell a cycle through the shared address adder.
// After reset every cell of the store is swept to zero, with s_tready low.
// The output register frees s_tready while a result waits; a held result stalls the
// next item only at its load cycle.
module text_console_writer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [tcw_pkg::IN_DATA_W-1:0]     s_tdata,  // [7:0] char_code, [18:8] cell_index
	input  logic                              s_tuser,  // [0] func
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [tcw_pkg::OUT_DATA_W-1:0]    m_tdata,  // [15:0] cell_word, [26:16] write_index,
	                                                    // [37:27] cursor_pos
	output logic [tcw_pkg::OUT_USER_W-1:0]    m_tuser,  // [0] wrote, [1] scrolled
	input  logic                              cfg_we,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tcw_pkg::CLR_W-1:0]         cfg_data
);
	import tcw_pkg::*;

	state_t state_q, state_nx;

	logic [ADDR_W-1:0] cnt_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] pos_q;
	logic [ADDR_W-1:0] base_q;
	logic [ADDR_W-1:0] clr_base_q;
	logic [CLR_W-1:0]  fg_q, bg_q;

	logic              res_read_q, res_wrote_q, res_range_q, res_scr_q;
	logic [CHAR_W-1:0] res_char_q;
	logic [IDX_W-1:0]  res_idx_q;

	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [OUT_USER_W-1:0] m_tuser_q;

	logic              accept, out_load;
	logic              in_func;
	logic [CHAR_W-1:0] in_char;
	logic [IDX_W-1:0]  in_idx;
	logic              in_range, put_char, do_nl, do_scroll;

	logic [SUM_W-1:0]  add_a, add_b, add_sum, add_wrap;
	logic [ADDR_W-1:0] mem_addr;
	logic [SUM_W-1:0]  base_sum;
	logic [ADDR_W-1:0] base_nx;

	mem_wr_t           mem_wr;
	logic              rd_en;
	logic [CHAR_W-1:0] rd_data;
	logic [WORD_W-1:0] out_word;

	assign in_func  = s_tuser;
	assign in_char  = s_tdata[CHAR_W-1:0];
	assign in_idx   = s_tdata[CHAR_W +: IDX_W];
	assign in_range = (in_idx < IDX_W'(CELLS));

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_load = (state_q == S_RESP) && (!m_tvalid_q || m_tready);

	assign put_char  = (in_func == FUNC_PUT) && (in_char != NEWLINE_CODE);
	assign do_nl     = (in_func == FUNC_PUT) &&
	                   ((in_char == NEWLINE_CODE) || (col_q == COL_W'(COLS - 1)));
	assign do_scroll = do_nl && (row_q == ROW_W'(ROWS - 1));

	// shared address unit: logical cell plus ring base, folded back into the store
	always_comb begin
		case (state_q)
			S_IDLE: begin
				add_a = (in_func == FUNC_READ) ? SUM_W'(in_idx) : SUM_W'(pos_q);
				add_b = SUM_W'(base_q);
			end
			S_CLEAR: begin
				add_a = SUM_W'(cnt_q);
				add_b = SUM_W'(clr_base_q);
			end
			default: begin
				add_a = SUM_W'(cnt_q);
				add_b = '0;
			end
		endcase
	end

	assign add_sum  = add_a + add_b;
	assign add_wrap = (add_sum >= SUM_W'(CELLS)) ? (add_sum - SUM_W'(CELLS)) : add_sum;
	assign mem_addr = add_wrap[ADDR_W-1:0];

	assign base_sum = SUM_W'(base_q) + SUM_W'(COLS);
	assign base_nx  = (base_sum >= SUM_W'(CELLS)) ? ADDR_W'(base_sum - SUM_W'(CELLS))
	                                               : ADDR_W'(base_sum);

	always_comb begin
		state_nx    = state_q;
		mem_wr.en   = 1'b0;
		mem_wr.addr = mem_addr;
		mem_wr.data = '0;
		rd_en       = 1'b0;
		case (state_q)
			S_INIT: begin
				mem_wr.en = 1'b1;
				if (cnt_q == ADDR_W'(CELLS - 1)) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					mem_wr.en   = put_char;
					mem_wr.data = in_char;
					rd_en       = (in_func == FUNC_READ);
					state_nx    = do_scroll ? S_CLEAR : S_RESP;
				end
			end
			S_CLEAR: begin
				mem_wr.en = 1'b1;
				if (cnt_q == ADDR_W'(COLS - 1)) begin
					state_nx = S_RESP;
				end
			end
			S_RESP: begin
				if (out_load) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_INIT;
		endcase
	end

	tcw_char_mem u_mem (
		.clk     (clk),
		.wr      (mem_wr),
		.rd_en   (rd_en),
		.rd_addr (mem_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			col_q  <= '0;
			row_q  <= '0;
			pos_q  <= '0;
			base_q <= '0;
		end else begin
			if (accept) begin
				cnt_q <= '0;
				if (do_nl) begin
					col_q <= '0;
					if (do_scroll) begin
						pos_q  <= ADDR_W'((ROWS - 1) * COLS);
						base_q <= base_nx;
					end else begin
						row_q <= row_q + 1'b1;
						pos_q <= pos_q - ADDR_W'(col_q) + ADDR_W'(COLS);
					end
				end else if (put_char) begin
					col_q <= col_q + 1'b1;
					pos_q <= pos_q + 1'b1;
				end
			end else if (state_q == S_INIT) begin
				cnt_q <= (cnt_q == ADDR_W'(CELLS - 1)) ? '0 : cnt_q + 1'b1;
			end else if (state_q == S_CLEAR) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= FG_RESET;
			bg_q <= BG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FG:  fg_q <= cfg_data;
				CFG_BG:  bg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-item result fields, captured at accept
	always_ff @(posedge clk) begin
		if (accept) begin
			clr_base_q  <= base_q;  // old top row becomes the cleared bottom row
			res_read_q  <= (in_func == FUNC_READ);
			res_wrote_q <= put_char;
			res_range_q <= in_range;
			res_scr_q   <= do_scroll;
			res_char_q  <= in_char;
			if (in_func == FUNC_READ) begin
				res_idx_q <= in_idx;
			end else if (put_char) begin
				res_idx_q <= IDX_W'(pos_q);
			end else begin
				res_idx_q <= '0;
			end
		end
	end

	always_comb begin
		if (res_read_q) begin
			out_word = res_range_q ? {bg_q, fg_q, rd_data} : '0;
		end else if (res_wrote_q) begin
			out_word = {bg_q, fg_q, res_char_q};
		end else begin
			out_word = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {{OUT_PAD_W{1'b0}}, IDX_W'(pos_q), res_idx_q, out_word};
			m_tuser_q <= {res_scr_q, res_wrote_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTH
	a_pos_linear: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q == ADDR_W'(row_q * COLS + col_q))
		else $error("cursor linear position out of step with row/col");

	a_cursor_held: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(pos_q))
		else $error("cursor moved without an accepted beat");

	a_out_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == S_RESP))
		else $error("result beat raised outside the response step");

	a_scroll_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_tuser_q[1]) |-> (row_q == ROW_W'(ROWS - 1)))
		else $error("scroll reported while cursor not on the bottom row");
`endif

endmodule
